// ===== hw/rtl/prdc_pkg.sv =====
// ----------------------------------------------------------------------------
// prdc_pkg
// Shared types and constants for the PID regulator with deadband and clamp.
// ----------------------------------------------------------------------------
package prdc_pkg;

  // fixed field widths
  localparam int DATA_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int ERR_W      = 17;
  localparam int DIFF_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_POLARITY     = 3'd3,
    CFG_DEADBAND     = 3'd4,
    CFG_OUTPUT_LIMIT = 3'd5
  } prdc_cfg_idx_t;

  // polarity codes, anything else disables the output
  localparam logic signed [1:0] POL_PASS   = 2'sb01;
  localparam logic signed [1:0] POL_INVERT = 2'sb11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

  // input transaction payload
  typedef struct packed {
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] setpoint;
  } prdc_in_t;

  // result transaction payload
  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     clamped;
  } prdc_out_t;

  // configuration register contents
  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [1:0]        polarity;
    logic [LIMIT_W-1:0]       deadband;
    logic [LIMIT_W-1:0]       output_limit;
  } prdc_cfg_t;

endpackage

// ===== hw/rtl/prdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// prdc_cfg_regs
// Configuration register file: gains, polarity, deadband and output limit.
// ----------------------------------------------------------------------------
module prdc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [prdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output prdc_pkg::prdc_cfg_t                 cfg
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p       <= '0;
      cfg.gain_i       <= '0;
      cfg.gain_d       <= '0;
      cfg.polarity     <= '0;
      cfg.deadband     <= '0;
      cfg.output_limit <= prdc_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (prdc_pkg::prdc_cfg_idx_t'(cfg_index))
        prdc_pkg::CFG_GAIN_P:       cfg.gain_p       <= cfg_data;
        prdc_pkg::CFG_GAIN_I:       cfg.gain_i       <= cfg_data;
        prdc_pkg::CFG_GAIN_D:       cfg.gain_d       <= cfg_data;
        prdc_pkg::CFG_POLARITY:     cfg.polarity     <= cfg_data[1:0];
        prdc_pkg::CFG_DEADBAND:     cfg.deadband     <= cfg_data[prdc_pkg::LIMIT_W-1:0];
        prdc_pkg::CFG_OUTPUT_LIMIT: cfg.output_limit <= cfg_data[prdc_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/prdc_error_stage.sv =====
// ----------------------------------------------------------------------------
// prdc_error_stage
// Deadband, error and derivative term, saturating integrator state.
// ----------------------------------------------------------------------------
module prdc_error_stage #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [prdc_pkg::DATA_W-1:0]     measured,
  input  logic signed [prdc_pkg::DATA_W-1:0]     setpoint,
  input  logic [prdc_pkg::LIMIT_W-1:0]           deadband,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [prdc_pkg::ERR_W-1:0]      err,
  output logic signed [prdc_pkg::DIFF_W-1:0]     diff,
  output logic signed [SUM_WIDTH-1:0]            sum
);

  localparam int EW = prdc_pkg::ERR_W;
  localparam int DW = prdc_pkg::DATA_W;

  logic signed [EW-1:0]        last_error;
  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [prdc_pkg::DIFF_W-1:0] diff_q;
  logic                        valid_q;

  logic [DW:0]                 mag;
  logic signed [DW-1:0]        meas_eff;
  logic signed [EW-1:0]        err_next;
  logic signed [prdc_pkg::DIFF_W-1:0] diff_next;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_next;
  logic                        take;

  assign in_ready  = !valid_q || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = valid_q;

  // deadband on the sample magnitude
  always_comb begin
    mag      = measured[DW-1] ? ((DW+1)'(0) - {1'b1, measured}) : {1'b0, measured};
    meas_eff = (mag < {{(DW+1-prdc_pkg::LIMIT_W){1'b0}}, deadband}) ? '0 : measured;
  end

  // error and difference to the previous error
  always_comb begin
    err_next  = {setpoint[DW-1], setpoint} - {meas_eff[DW-1], meas_eff};
    diff_next = {err_next[EW-1], err_next} - {last_error[EW-1], last_error};
  end

  // saturating integrator
  always_comb begin
    sum_wide = {error_sum[SUM_WIDTH-1], error_sum}
             + {{(SUM_WIDTH+1-EW){err_next[EW-1]}}, err_next};
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                     : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_next = sum_wide[SUM_WIDTH-1:0];
    end
  end

  // state updates once per transaction; it also serves as the stage output
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q    <= 1'b0;
      last_error <= '0;
      error_sum  <= '0;
    end else begin
      if (in_ready) begin
        valid_q <= in_valid;
      end
      if (take) begin
        last_error <= err_next;
        error_sum  <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      diff_q <= diff_next;
    end
  end

  assign err  = last_error;
  assign sum  = error_sum;
  assign diff = diff_q;

endmodule

// ===== hw/rtl/prdc_product_stage.sv =====
// ----------------------------------------------------------------------------
// prdc_product_stage
// Three parallel gain multipliers with registered products.
// ----------------------------------------------------------------------------
module prdc_product_stage #(
  parameter int SUM_WIDTH = 32
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   in_valid,
  output logic                                                   in_ready,
  input  logic signed [prdc_pkg::ERR_W-1:0]                      err,
  input  logic signed [prdc_pkg::DIFF_W-1:0]                     diff,
  input  logic signed [SUM_WIDTH-1:0]                            sum,
  input  prdc_pkg::prdc_cfg_t                                    cfg,
  output logic                                                   out_valid,
  input  logic                                                   out_ready,
  output logic signed [prdc_pkg::GAIN_W+prdc_pkg::ERR_W-1:0]     prod_p,
  output logic signed [prdc_pkg::GAIN_W+SUM_WIDTH-1:0]           prod_i,
  output logic signed [prdc_pkg::GAIN_W+prdc_pkg::DIFF_W-1:0]    prod_d
);

  localparam int PW = prdc_pkg::GAIN_W + prdc_pkg::ERR_W;
  localparam int IW = prdc_pkg::GAIN_W + SUM_WIDTH;
  localparam int DW = prdc_pkg::GAIN_W + prdc_pkg::DIFF_W;

  logic valid_q;
  logic take;

  assign in_ready  = !valid_q || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  // signed products at full width
  always_ff @(posedge clk) begin
    if (take) begin
      prod_p <= PW'(cfg.gain_p) * PW'(err);
      prod_i <= IW'(cfg.gain_i) * IW'(sum);
      prod_d <= DW'(cfg.gain_d) * DW'(diff);
    end
  end

endmodule

// ===== hw/rtl/prdc_output_stage.sv =====
// ----------------------------------------------------------------------------
// prdc_output_stage
// Term sum, polarity, symmetric clamp and truncation to the integer drive.
// ----------------------------------------------------------------------------
module prdc_output_stage #(
  parameter int SUM_WIDTH      = 32,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   in_valid,
  output logic                                                   in_ready,
  input  logic signed [prdc_pkg::GAIN_W+prdc_pkg::ERR_W-1:0]     prod_p,
  input  logic signed [prdc_pkg::GAIN_W+SUM_WIDTH-1:0]           prod_i,
  input  logic signed [prdc_pkg::GAIN_W+prdc_pkg::DIFF_W-1:0]    prod_d,
  input  prdc_pkg::prdc_cfg_t                                    cfg,
  output logic                                                   out_valid,
  input  logic                                                   out_ready,
  output prdc_pkg::prdc_out_t                                    out_data
);

  // room for three products plus negation
  localparam int ACC_W = SUM_WIDTH + prdc_pkg::GAIN_W + 3;
  localparam logic signed [ACC_W-1:0] ROUND_ADJ = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  logic                    valid_q;
  logic                    take;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_pol;
  logic signed [ACC_W-1:0] bound;
  logic signed [ACC_W-1:0] held;
  logic signed [ACC_W-1:0] adj;
  logic signed [ACC_W-1:0] shifted;
  logic                    clamped_next;

  assign in_ready  = !valid_q || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = valid_q;

  // sum of terms and polarity
  always_comb begin
    acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
    case (cfg.polarity)
      prdc_pkg::POL_PASS:   acc_pol = acc;
      prdc_pkg::POL_INVERT: acc_pol = -acc;
      default:              acc_pol = '0;
    endcase
  end

  // clamp to the limit in the fixed point scale, then truncate toward zero
  always_comb begin
    bound = $signed({{(ACC_W-prdc_pkg::LIMIT_W){1'b0}}, cfg.output_limit}) <<< GAIN_FRAC_BITS;
    clamped_next = 1'b0;
    held         = acc_pol;
    if (acc_pol > bound) begin
      held         = bound;
      clamped_next = 1'b1;
    end else if (acc_pol < -bound) begin
      held         = -bound;
      clamped_next = 1'b1;
    end
    adj     = held[ACC_W-1] ? (held + ROUND_ADJ) : held;
    shifted = adj >>> GAIN_FRAC_BITS;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.drive   <= shifted[prdc_pkg::DATA_W-1:0];
      out_data.clamped <= clamped_next;
    end
  end

endmodule

// ===== hw/rtl/pid_regulator_deadband_clamp.sv =====
// ----------------------------------------------------------------------------
// pid_regulator_deadband_clamp
// Positional PID regulator with input deadband, polarity and output clamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one measured sample and
//   one setpoint per transaction; the output channel out_valid/out_stall/
//   out_data returns one drive value and a clamped flag per transaction, in
//   order. Gains, polarity, deadband and output limit are written through
//   cfg_we/cfg_index/cfg_data while no transaction is in flight.
//   A transaction passes the input, error/integrator and multiplier
//   registers in order before the result register loads and offers it.
//   Throughput: one transaction per cycle while out_stall is low. The four
//   register stages (input, error/integrator, multipliers, clamp/result) each
//   pass one item a cycle; the integral and previous error are the only loops.
//   Reset clears the error history, the integral, the valid flags and the config
//   registers (output limit goes to full scale) and empties the pipeline.
//   When the receiver stalls, the result holds and stages fill behind it;
//   in_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module pid_regulator_deadband_clamp #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SUM_WIDTH      = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [prdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  prdc_pkg::prdc_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output prdc_pkg::prdc_out_t                 out_data
);

  prdc_pkg::prdc_cfg_t cfg;
  prdc_pkg::prdc_in_t  in_q;
  logic                in_q_valid;
  logic                in_ready;

  logic                                              err_ready;
  logic                                              err_valid;
  logic signed [prdc_pkg::ERR_W-1:0]                 err;
  logic signed [prdc_pkg::DIFF_W-1:0]                diff;
  logic signed [SUM_WIDTH-1:0]                       sum;

  logic                                              prod_ready;
  logic                                              prod_valid;
  logic signed [prdc_pkg::GAIN_W+prdc_pkg::ERR_W-1:0]  prod_p;
  logic signed [prdc_pkg::GAIN_W+SUM_WIDTH-1:0]        prod_i;
  logic signed [prdc_pkg::GAIN_W+prdc_pkg::DIFF_W-1:0] prod_d;

  logic                                              res_ready;

  prdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  assign in_ready = !in_q_valid || err_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  prdc_error_stage #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_error (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_q_valid),
    .in_ready  (err_ready),
    .measured  (in_q.measured),
    .setpoint  (in_q.setpoint),
    .deadband  (cfg.deadband),
    .out_valid (err_valid),
    .out_ready (prod_ready),
    .err       (err),
    .diff      (diff),
    .sum       (sum)
  );

  prdc_product_stage #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_product (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (err_valid),
    .in_ready  (prod_ready),
    .err       (err),
    .diff      (diff),
    .sum       (sum),
    .cfg       (cfg),
    .out_valid (prod_valid),
    .out_ready (res_ready),
    .prod_p    (prod_p),
    .prod_i    (prod_i),
    .prod_d    (prod_d)
  );

  prdc_output_stage #(
    .SUM_WIDTH      (SUM_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_output (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (res_ready),
    .prod_p    (prod_p),
    .prod_i    (prod_i),
    .prod_d    (prod_d),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== dv/pid_regulator_deadband_clamp_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_regulator_deadband_clamp_tb
// Self-checking bench for the PID regulator. A directed table walks reset
// behavior, polarity codes, truncation, zero limit and the deadband edges,
// a run of full-scale errors ramps the integral up, down and back, and random
// phases with varied register settings follow. Every result is compared with
// its table value or an in-bench model of the regulator under random idling and stalls.
// ----------------------------------------------------------------------------
module pid_regulator_deadband_clamp_tb;
  import prdc_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int SUM_W = 32;
  localparam longint SCALE = longint'(1) <<< FRAC_BITS;
  localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  // polarity codes the package leaves unnamed
  localparam logic signed [1:0] POL_OFF  = 2'sb00;
  localparam logic signed [1:0] POL_VOID = 2'sb10;

  localparam int SAT_RUN      = 40;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 220;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 10;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef enum logic {STEP_WRITE, STEP_ITEM} step_kind_t;

  typedef struct {
    step_kind_t    kind;
    prdc_cfg_idx_t idx;
    logic [15:0]   value;
    prdc_in_t      item;
    bit            known;
    prdc_out_t     result;
  } dir_step_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  prdc_in_t   in_data;
  logic       out_valid;
  logic       out_stall;
  prdc_out_t  out_data;

  // model state and register shadow
  prdc_cfg_t                    shadow;
  logic signed [DIFF_W-1:0]     prev_err;
  logic signed [SUM_W-1:0]      err_integral;

  prdc_out_t drive_due[$];
  prdc_out_t due_head;
  dir_step_t plan[$];
  int        mismatches;
  int        in_accepts;
  bit        calm;

  pid_regulator_deadband_clamp #(
    .GAIN_FRAC_BITS(FRAC_BITS),
    .SUM_WIDTH(SUM_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one regulator step: deadband, error history, saturating integral,
  // gains, polarity, clamp, truncation toward zero
  function automatic prdc_out_t pid_step(prdc_in_t it);
    longint meas, mag, err, diff, sum, acc, bound, drv;
    prdc_out_t res;
    meas = it.measured;
    mag = (meas < 0) ? -meas : meas;
    if (mag < longint'(shadow.deadband)) meas = 0;
    err = longint'(it.setpoint) - meas;
    diff = err - longint'(prev_err);
    prev_err = err[DIFF_W-1:0];
    sum = longint'(err_integral) + err;
    if (sum > SUM_MAX) sum = SUM_MAX;
    if (sum < SUM_MIN) sum = SUM_MIN;
    err_integral = sum[SUM_W-1:0];
    acc = longint'(shadow.gain_p) * err + longint'(shadow.gain_i) * sum
        + longint'(shadow.gain_d) * diff;
    if (shadow.polarity == POL_INVERT) acc = -acc;
    else if (shadow.polarity != POL_PASS) acc = 0;
    bound = longint'(shadow.output_limit) * SCALE;
    res.clamped = 1'b0;
    if (acc > bound) begin
      acc = bound;
      res.clamped = 1'b1;
    end else if (acc < -bound) begin
      acc = -bound;
      res.clamped = 1'b1;
    end
    drv = acc / SCALE;
    res.drive = drv[DATA_W-1:0];
    return res;
  endfunction

  function automatic dir_step_t step_cfg(prdc_cfg_idx_t idx, logic [15:0] value);
    dir_step_t s;
    s.kind = STEP_WRITE;
    s.idx = idx;
    s.value = value;
    s.item = '0;
    s.known = 1'b0;
    s.result = '0;
    return s;
  endfunction

  function automatic dir_step_t step_free(int meas, int setp);
    dir_step_t s;
    s.kind = STEP_ITEM;
    s.idx = CFG_GAIN_P;
    s.value = '0;
    s.item.measured = meas[DATA_W-1:0];
    s.item.setpoint = setp[DATA_W-1:0];
    s.known = 1'b0;
    s.result = '0;
    return s;
  endfunction

  function automatic dir_step_t step_known(int meas, int setp, int drv, bit clip);
    dir_step_t s;
    s = step_free(meas, setp);
    s.known = 1'b1;
    s.result.drive = drv[DATA_W-1:0];
    s.result.clamped = clip;
    return s;
  endfunction

  function automatic logic [15:0] rand_gain();
    if ($urandom_range(1) == 0) return 16'($urandom_range(1200) - 600);
    return 16'($urandom);
  endfunction

  // mix of full-range, tracking, near-deadband and full-scale samples
  function automatic prdc_in_t rand_item();
    prdc_in_t it;
    int edge_val;
    it.setpoint = 16'($urandom);
    it.measured = 16'($urandom);
    case ($urandom_range(9))
      4, 5, 6: it.measured = it.setpoint + 16'($urandom_range(64) - 32);
      7, 8: begin
        edge_val = int'(shadow.deadband) + int'($urandom_range(4)) - 2;
        it.measured = ($urandom_range(1) == 0) ? 16'(edge_val) : 16'(-edge_val);
      end
      9: it.measured = ($urandom_range(1) == 0) ? 16'h8000 : 16'h7FFF;
      default: ;
    endcase
    return it;
  endfunction

  task automatic flag(string what);
    if (mismatches < 10) $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  // register write, shadow follows at once
  task automatic write_reg(prdc_cfg_idx_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_GAIN_P:       shadow.gain_p = value;
      CFG_GAIN_I:       shadow.gain_i = value;
      CFG_GAIN_D:       shadow.gain_d = value;
      CFG_POLARITY:     shadow.polarity = value[1:0];
      CFG_DEADBAND:     shadow.deadband = value[LIMIT_W-1:0];
      CFG_OUTPUT_LIMIT: shadow.output_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering and let every pending result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (drive_due.size() != 0);
  endtask

  // offer one transaction, record what it should produce once accepted
  task automatic send_item(prdc_in_t it, bit known = 1'b0, prdc_out_t typed = '0);
    prdc_out_t predicted;
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predicted = pid_step(it);
    drive_due.push_back(known ? typed : predicted);
    in_accepts++;
    @(negedge clk);
  endtask

  // register settings for one random phase
  task automatic load_phase(int ph);
    logic [15:0] gp, gi, gd, db, lim;
    logic signed [1:0] pol;
    gp = rand_gain();
    gi = rand_gain();
    gd = rand_gain();
    db = ($urandom_range(1) == 0) ? 16'($urandom_range(300)) : 16'($urandom_range(32767));
    lim = ($urandom_range(3) == 0) ? 16'($urandom_range(50)) : 16'($urandom_range(32767));
    case ($urandom_range(3))
      0: pol = POL_PASS;
      1: pol = POL_INVERT;
      2: pol = POL_OFF;
      default: pol = POL_VOID;
    endcase
    case (ph)
      0: begin
        gp = 16'd256; gi = 16'd1; gd = 16'd64; pol = POL_PASS;
        db = 16'd0; lim = 16'd32767;
      end
      1: begin
        gp = 16'h7FFF; gi = 16'h8000; gd = 16'h7FFF; pol = POL_INVERT;
        db = 16'd32767; lim = 16'd0;
      end
      3: begin
        gp = 16'h8000; gi = 16'd0; gd = 16'h8000; pol = POL_PASS;
        db = 16'd0; lim = 16'd32767;
      end
      default: ;
    endcase
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_POLARITY, pol);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_OUTPUT_LIMIT, lim);
  endtask

  // result side: random stalls plus one long hold-off to back up the pipe
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && in_accepts >= HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  // compare each result transaction with the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (drive_due.size() == 0) begin
        flag($sformatf("unexpected result drive %0d clamped %0b",
                       out_data.drive, out_data.clamped));
      end else begin
        due_head = drive_due.pop_front();
        if (out_data.drive !== due_head.drive || out_data.clamped !== due_head.clamped)
          flag($sformatf("drive exp %0d got %0d, clamped exp %0b got %0b",
                         due_head.drive, out_data.drive,
                         due_head.clamped, out_data.clamped));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[pid_regulator_deadband_clamp] ERROR");
    $finish;
  end

  initial begin : stimulus
    prdc_in_t it;
    dir_step_t s;
    int ph;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_GAIN_P;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    mismatches = 0;
    in_accepts = 0;
    calm = 1'b0;
    shadow = '0;
    shadow.output_limit = LIMIT_RESET;
    prev_err = '0;
    err_integral = '0;

    // after reset the output is disabled
    plan.push_back(step_known(-32768, 32767, 0, 0));
    plan.push_back(step_known(32767, -32768, 0, 0));
    // unity proportional gain, full-scale errors
    plan.push_back(step_cfg(CFG_GAIN_P, 16'd256));
    plan.push_back(step_cfg(CFG_POLARITY, POL_PASS));
    plan.push_back(step_known(0, 32767, 32767, 0));
    plan.push_back(step_known(32767, -32768, -32767, 1));
    plan.push_back(step_known(0, 100, 100, 0));
    plan.push_back(step_known(-32768, -32768, 0, 0));
    // inverted, meaningless and disabled polarity
    plan.push_back(step_cfg(CFG_POLARITY, POL_INVERT));
    plan.push_back(step_known(0, 100, -100, 0));
    plan.push_back(step_known(0, 32767, -32767, 0));
    plan.push_back(step_cfg(CFG_POLARITY, POL_VOID));
    plan.push_back(step_known(0, 1000, 0, 0));
    plan.push_back(step_cfg(CFG_POLARITY, POL_OFF));
    plan.push_back(step_known(0, -1000, 0, 0));
    // half gain, fractions truncate toward zero
    plan.push_back(step_cfg(CFG_POLARITY, POL_PASS));
    plan.push_back(step_cfg(CFG_GAIN_P, 16'd128));
    plan.push_back(step_known(0, 3, 1, 0));
    plan.push_back(step_known(0, -3, -1, 0));
    // zero limit
    plan.push_back(step_cfg(CFG_OUTPUT_LIMIT, 16'd0));
    plan.push_back(step_known(0, 5, 0, 1));
    plan.push_back(step_known(0, 0, 0, 0));
    // deadband edges
    plan.push_back(step_cfg(CFG_OUTPUT_LIMIT, 16'd32767));
    plan.push_back(step_cfg(CFG_GAIN_P, 16'd256));
    plan.push_back(step_cfg(CFG_DEADBAND, 16'd100));
    plan.push_back(step_known(99, 0, 0, 0));
    plan.push_back(step_known(-99, 0, 0, 0));
    plan.push_back(step_known(100, 0, -100, 0));
    plan.push_back(step_known(-100, 0, 100, 0));
    // full deadband, full-scale negative sample passes through
    plan.push_back(step_cfg(CFG_DEADBAND, 16'd32767));
    plan.push_back(step_known(-32768, 0, 32767, 1));
    plan.push_back(step_known(32766, 5, 5, 0));
    plan.push_back(step_known(32767, 0, -32767, 0));
    // extreme gains on all three terms
    plan.push_back(step_cfg(CFG_DEADBAND, 16'd0));
    plan.push_back(step_cfg(CFG_GAIN_P, 16'h8000));
    plan.push_back(step_cfg(CFG_GAIN_I, 16'h7FFF));
    plan.push_back(step_cfg(CFG_GAIN_D, 16'h8000));
    plan.push_back(step_free(12, -7));
    plan.push_back(step_free(-32768, 32767));
    // moderate mixed gains
    plan.push_back(step_cfg(CFG_GAIN_P, 16'd300));
    plan.push_back(step_cfg(CFG_GAIN_I, 16'd2));
    plan.push_back(step_cfg(CFG_GAIN_D, 16'(-700)));
    plan.push_back(step_cfg(CFG_OUTPUT_LIMIT, 16'd20000));
    plan.push_back(step_free(10, -25));
    plan.push_back(step_free(-40, 3));

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[k]) begin
      s = plan[k];
      if (s.kind == STEP_WRITE) begin
        wait_idle();
        write_reg(s.idx, s.value);
      end else begin
        send_item(s.item, s.known, s.result);
      end
    end

    // ramp the integral with full-scale errors up, down and back
    wait_idle();
    write_reg(CFG_GAIN_P, 16'd0);
    write_reg(CFG_GAIN_I, 16'd1);
    write_reg(CFG_GAIN_D, 16'd0);
    write_reg(CFG_POLARITY, POL_PASS);
    write_reg(CFG_DEADBAND, 16'd0);
    write_reg(CFG_OUTPUT_LIMIT, 16'd32767);
    it.measured = 16'sh8000;
    it.setpoint = 16'sh7FFF;
    repeat (SAT_RUN) send_item(it);
    it.measured = 16'sh7FFF;
    it.setpoint = 16'sh8000;
    repeat (2 * SAT_RUN) send_item(it);
    it.measured = 16'sh8000;
    it.setpoint = 16'sh7FFF;
    repeat (SAT_RUN) send_item(it);

    // random phases, one of them with no idling on either side
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      load_phase(ph);
      calm = (ph == 2);
      repeat (PHASE_ITEMS) send_item(rand_item());
    end
    calm = 1'b0;

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("[pid_regulator_deadband_clamp] OK");
    end else begin
      $display("[pid_regulator_deadband_clamp] ERROR");
    end
    $finish;
  end

endmodule
